// ===== hw/rtl/fau_pkg.sv =====
// Shared constants, codes and control types for the fraction arithmetic unit.
package fau_pkg;

   localparam int OPERAND_BITS_DEF = 16;

   localparam int NUM_W = 34;
   localparam int DEN_W = 31;
   localparam int TYPE_W = 2;

   localparam int RSP_FIELDS_W = NUM_W + DEN_W + 1;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [TYPE_W-1:0] OP_ADD = 2'd0;
   localparam logic [TYPE_W-1:0] OP_SUB = 2'd1;
   localparam logic [TYPE_W-1:0] OP_MUL = 2'd2;
   localparam logic [TYPE_W-1:0] OP_DIV = 2'd3;

   localparam logic [1:0] MUL_NUM0 = 2'd0;
   localparam logic [1:0] MUL_NUM1 = 2'd1;
   localparam logic [1:0] MUL_DEN  = 2'd2;

   localparam logic DIV_SEL_NUM = 1'b0;
   localparam logic DIV_SEL_DEN = 1'b1;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum_en;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_sel;
      logic       div_step;
      logic       save_num;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_last;
   } status_type;

endpackage

// ===== hw/rtl/fau_ctrl.sv =====
// Sequencing state machine for the fraction arithmetic unit.
module fau_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  fau_pkg::status_type status,
   output fau_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL0 = 4'd1;
   localparam logic [3:0] S_MUL1 = 4'd2;
   localparam logic [3:0] S_MUL2 = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_GINI = 4'd5;
   localparam logic [3:0] S_GCD  = 4'd6;
   localparam logic [3:0] S_DIVN = 4'd7;
   localparam logic [3:0] S_SWAP = 4'd8;
   localparam logic [3:0] S_DIVD = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.mul_sel = fau_pkg::MUL_NUM0;
      cmd.div_sel = fau_pkg::DIV_SEL_NUM;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = fau_pkg::MUL_NUM0;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = fau_pkg::MUL_NUM1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = fau_pkg::MUL_DEN;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in = S_GINI;
         end
         S_GINI: begin
            cmd.gcd_init = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cmd.div_sel = fau_pkg::DIV_SEL_NUM;
               state_in = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_SWAP;
            end
         end
         S_SWAP: begin
            cmd.save_num = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_sel = fau_pkg::DIV_SEL_DEN;
            state_in = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/fau_dp.sv =====
// Datapath: cross products, signed sum, binary GCD and bit-serial exact divider.
module fau_dp #(
   parameter int OPERAND_BITS = fau_pkg::OPERAND_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fau_pkg::cmd_type                cmd,
   output fau_pkg::status_type             status,
   input  logic [fau_pkg::TYPE_W-1:0]      req_type,
   input  logic signed [OPERAND_BITS-1:0]  a_num,
   input  logic signed [OPERAND_BITS-1:0]  a_den,
   input  logic signed [OPERAND_BITS-1:0]  b_num,
   input  logic signed [OPERAND_BITS-1:0]  b_den,
   output logic signed [fau_pkg::NUM_W-1:0] res_num,
   output logic [fau_pkg::DEN_W-1:0]       res_den,
   output logic                            zero_den
);

   localparam int B = OPERAND_BITS;
   localparam int MAG_W = 2 * B;
   localparam int KW = $clog2(MAG_W + 1);
   localparam int CW = $clog2(MAG_W);
   localparam int EXT_W = (MAG_W > fau_pkg::NUM_W) ? MAG_W : fau_pkg::NUM_W;

   logic [fau_pkg::TYPE_W-1:0] op_ff, op_in;
   logic [B-1:0] an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   logic [MAG_W-1:0] p0_mag_ff, p0_mag_in, p1_mag_ff, p1_mag_in;
   logic p0_neg_ff, p0_neg_in, p1_neg_ff, p1_neg_in;
   logic [MAG_W-1:0] den_mag_ff, den_mag_in, num_mag_ff, num_mag_in;
   logic den_neg_ff, den_neg_in, num_neg_ff, num_neg_in;
   logic [MAG_W-1:0] u_ff, u_in, v_ff, v_in, g_ff, g_in;
   logic [KW-1:0] k_ff, k_in;
   logic gcd_done_ff, gcd_done_in;
   logic [MAG_W-1:0] rem_ff, rem_in, quo_ff, quo_in, nm_ff, nm_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [fau_pkg::NUM_W-1:0] res_num_ff, res_num_in;
   logic [fau_pkg::DEN_W-1:0] res_den_ff, res_den_in;
   logic zero_den_ff, zero_den_in;

   logic [B-1:0] mx, my;
   logic mx_s, my_s;
   logic [B-1:0] mx_mag, my_mag;
   logic [MAG_W-1:0] prod;
   logic prod_neg;
   logic t_neg;
   logic [MAG_W-1:0] s_mag;
   logic s_neg;
   logic [MAG_W:0] trial;
   logic [MAG_W:0] trial_diff;
   logic [MAG_W-1:0] u_minus_v, v_minus_u;
   logic out_neg;
   logic [EXT_W-1:0] nm_ext, dm_ext, nout;

   assign status.gcd_done = gcd_done_ff;
   assign status.div_last = (cnt_ff == CW'(MAG_W - 1));

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign zero_den = zero_den_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         fau_pkg::MUL_NUM0: begin
            mx = an_ff;
            my = (op_ff == fau_pkg::OP_MUL) ? bn_ff : bd_ff;
         end
         fau_pkg::MUL_NUM1: begin
            mx = bn_ff;
            my = ad_ff;
         end
         fau_pkg::MUL_DEN: begin
            mx = ad_ff;
            my = (op_ff == fau_pkg::OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mx = an_ff;
            my = bd_ff;
         end
      endcase
      mx_s = mx[B-1];
      my_s = my[B-1];
      mx_mag = mx_s ? (~mx + 1'b1) : mx;
      my_mag = my_s ? (~my + 1'b1) : my;
      prod = MAG_W'(mx_mag) * MAG_W'(my_mag);
      prod_neg = (mx_s != my_s) && (prod != '0);
   end

   always_comb begin
      t_neg = p1_neg_ff;
      if (op_ff == fau_pkg::OP_SUB) begin
         t_neg = !p1_neg_ff && (p1_mag_ff != '0);
      end
      if (p0_neg_ff == t_neg) begin
         s_mag = p0_mag_ff + p1_mag_ff;
         s_neg = p0_neg_ff;
      end else if (p0_mag_ff >= p1_mag_ff) begin
         s_mag = p0_mag_ff - p1_mag_ff;
         s_neg = p0_neg_ff;
      end else begin
         s_mag = p1_mag_ff - p0_mag_ff;
         s_neg = t_neg;
      end
      if (s_mag == '0) begin
         s_neg = 1'b0;
      end
   end

   assign u_minus_v = u_ff - v_ff;
   assign v_minus_u = v_ff - u_ff;
   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign trial_diff = trial - {1'b0, g_ff};

   assign out_neg = (num_neg_ff != den_neg_ff) && (nm_ff != '0);
   assign nm_ext = EXT_W'(nm_ff);
   assign dm_ext = EXT_W'(quo_ff);
   assign nout = out_neg ? (~nm_ext + 1'b1) : nm_ext;

   always_comb begin
      op_in = op_ff;
      an_in = an_ff;
      ad_in = ad_ff;
      bn_in = bn_ff;
      bd_in = bd_ff;
      p0_mag_in = p0_mag_ff;
      p0_neg_in = p0_neg_ff;
      p1_mag_in = p1_mag_ff;
      p1_neg_in = p1_neg_ff;
      den_mag_in = den_mag_ff;
      den_neg_in = den_neg_ff;
      num_mag_in = num_mag_ff;
      num_neg_in = num_neg_ff;
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      g_in = g_ff;
      gcd_done_in = gcd_done_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      nm_in = nm_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      zero_den_in = zero_den_ff;

      if (cmd.load) begin
         op_in = req_type;
         an_in = a_num;
         ad_in = a_den;
         bn_in = b_num;
         bd_in = b_den;
      end

      if (cmd.mul_en) begin
         unique case (cmd.mul_sel)
            fau_pkg::MUL_NUM0: begin
               p0_mag_in = prod;
               p0_neg_in = prod_neg;
            end
            fau_pkg::MUL_NUM1: begin
               p1_mag_in = prod;
               p1_neg_in = prod_neg;
            end
            fau_pkg::MUL_DEN: begin
               den_mag_in = prod;
               den_neg_in = prod_neg;
            end
            default: begin
               den_mag_in = den_mag_ff;
            end
         endcase
      end

      if (cmd.sum_en) begin
         if (op_ff == fau_pkg::OP_ADD || op_ff == fau_pkg::OP_SUB) begin
            num_mag_in = s_mag;
            num_neg_in = s_neg;
         end else begin
            num_mag_in = p0_mag_ff;
            num_neg_in = p0_neg_ff;
         end
      end

      if (cmd.gcd_init) begin
         u_in = num_mag_ff;
         v_in = den_mag_ff;
         k_in = '0;
         gcd_done_in = 1'b0;
         if (num_mag_ff == '0 && den_mag_ff == '0) begin
            g_in = MAG_W'(1);
            gcd_done_in = 1'b1;
         end else if (num_mag_ff == '0) begin
            g_in = den_mag_ff;
            gcd_done_in = 1'b1;
         end else if (den_mag_ff == '0) begin
            g_in = num_mag_ff;
            gcd_done_in = 1'b1;
         end
      end

      if (cmd.gcd_step) begin
         priority if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff == v_ff) begin
            g_in = u_ff << k_ff;
            gcd_done_in = 1'b1;
         end else if (u_ff > v_ff) begin
            u_in = u_minus_v >> 1;
         end else begin
            v_in = v_minus_u >> 1;
         end
      end

      if (cmd.save_num) begin
         nm_in = quo_ff;
      end

      if (cmd.div_init) begin
         quo_in = (cmd.div_sel == fau_pkg::DIV_SEL_DEN) ? den_mag_ff : num_mag_ff;
         rem_in = '0;
         cnt_in = '0;
      end

      if (cmd.div_step) begin
         if (!trial_diff[MAG_W]) begin
            rem_in = trial_diff[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[MAG_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.out_load) begin
         res_num_in = nout[fau_pkg::NUM_W-1:0];
         res_den_in = dm_ext[fau_pkg::DEN_W-1:0];
         zero_den_in = (quo_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gcd_done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         gcd_done_ff <= gcd_done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      an_ff <= an_in;
      ad_ff <= ad_in;
      bn_ff <= bn_in;
      bd_ff <= bd_in;
      p0_mag_ff <= p0_mag_in;
      p0_neg_ff <= p0_neg_in;
      p1_mag_ff <= p1_mag_in;
      p1_neg_ff <= p1_neg_in;
      den_mag_ff <= den_mag_in;
      den_neg_ff <= den_neg_in;
      num_mag_ff <= num_mag_in;
      num_neg_ff <= num_neg_in;
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      g_ff <= g_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      nm_ff <= nm_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      zero_den_ff <= zero_den_in;
   end

endmodule

// ===== hw/rtl/fraction_arithmetic_unit.sv =====
// Top level of the fraction arithmetic unit: controller plus datapath.
// A request passes load, three products, sum, GCD init, binary GCD steps (none if a raw part
// is zero) and two bit-serial divisions by the GCD, MAG_W = 2*OPERAND_BITS bits wide.
// One transaction at a time: a request is accepted only after the previous result is loaded,
// which waits while rsp_tready holds the previous result in the output register.
// Reset clears the controller and the output valid; no result is pending after reset.
module fraction_arithmetic_unit #(
   parameter int OPERAND_BITS = fau_pkg::OPERAND_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_type[1:0], a_num, a_den, b_num, b_den (OPERAND_BITS each), zero pad
   input  logic [((fau_pkg::TYPE_W + 4 * OPERAND_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // res_num[33:0], res_den[64:34], zero_den[65], zero pad
   output logic [fau_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int B = OPERAND_BITS;
   localparam int TW = fau_pkg::TYPE_W;
   localparam int RSP_PAD = fau_pkg::RSP_TDATA_W - fau_pkg::RSP_FIELDS_W;

   fau_pkg::cmd_type    cmd;
   fau_pkg::status_type status;

   logic signed [fau_pkg::NUM_W-1:0] res_num;
   logic [fau_pkg::DEN_W-1:0]        res_den;
   logic                             zero_den;

   fau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   fau_dp #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_type (req_tdata[TW-1:0]),
      .a_num    (req_tdata[TW +: B]),
      .a_den    (req_tdata[TW + B +: B]),
      .b_num    (req_tdata[TW + 2 * B +: B]),
      .b_den    (req_tdata[TW + 3 * B +: B]),
      .res_num  (res_num),
      .res_den  (res_den),
      .zero_den (zero_den)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, zero_den, res_den, res_num};

endmodule

// ===== test/fraction_arithmetic_unit_tb.sv =====
// Self-checking testbench for fraction_arithmetic_unit against a reduced-fraction predictor.
`timescale 1ns / 1ps

module fraction_arithmetic_unit_tb;

   localparam int OPW = fau_pkg::OPERAND_BITS_DEF;
   localparam int TW = fau_pkg::TYPE_W;
   localparam int NW = fau_pkg::NUM_W;
   localparam int DW = fau_pkg::DEN_W;
   localparam int REQ_W = ((TW + 4 * OPW + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 800;
   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD = 400;
   localparam int TAIL_CYCLES = 150;

   typedef struct {
      logic [TW-1:0]         op;
      logic signed [OPW-1:0] a_num;
      logic signed [OPW-1:0] a_den;
      logic signed [OPW-1:0] b_num;
      logic signed [OPW-1:0] b_den;
      logic                  drain_first;
   } frac_op_type;

   typedef struct {
      logic signed [NW-1:0] num;
      logic [DW-1:0]        den;
      logic                 zero_den;
   } frac_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [fau_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   frac_op_type pending_ops[$];
   frac_result_type fractions_due[$];
   frac_op_type in_flight;
   int items_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int send_gap = 0;
   int recv_wait = 0;
   logic long_hold_done = 1'b0;
   int idle_cycles = 0;

   fraction_arithmetic_unit #(.OPERAND_BITS(OPW)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic frac_result_type reduce_fraction(frac_op_type r);
      longint an, ad, bn, bd, num, den, nmag, dmag, x, y, t;
      frac_result_type e;
      an = r.a_num;
      ad = r.a_den;
      bn = r.b_num;
      bd = r.b_den;
      case (r.op)
         fau_pkg::OP_ADD: begin
            num = an * bd + bn * ad;
            den = ad * bd;
         end
         fau_pkg::OP_SUB: begin
            num = an * bd - bn * ad;
            den = ad * bd;
         end
         fau_pkg::OP_MUL: begin
            num = an * bn;
            den = ad * bd;
         end
         default: begin
            num = an * bd;
            den = ad * bn;
         end
      endcase
      nmag = (num < 0) ? -num : num;
      dmag = (den < 0) ? -den : den;
      x = nmag;
      y = dmag;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      if (x == 0) x = 1;
      nmag = nmag / x;
      dmag = dmag / x;
      e.num = NW'((((num < 0) != (den < 0)) && nmag != 0) ? -nmag : nmag);
      e.den = dmag[DW-1:0];
      e.zero_den = (dmag == 0);
      return e;
   endfunction

   task automatic queue_op(input logic [TW-1:0] op, input int an, input int ad,
                           input int bn, input int bd, input logic drain);
      frac_op_type it;
      it.op = op;
      it.a_num = an[OPW-1:0];
      it.a_den = ad[OPW-1:0];
      it.b_num = bn[OPW-1:0];
      it.b_den = bd[OPW-1:0];
      it.drain_first = drain;
      pending_ops.push_back(it);
   endtask

   function automatic int draw_operand(int mode);
      int v;
      case (mode)
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: v = int'($urandom_range(0, 24)) - 12;
         default: v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      endcase
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      frac_op_type nxt;
      int gap;
      logic took;
      took = req_tvalid && req_tready;
      if (took) begin
         fractions_due.push_back(reduce_fraction(in_flight));
         items_sent++;
      end
      if (took)
         gap = (((items_sent / 64) % 3) == 2) ? 0 : int'($urandom_range(0, 15));
      else
         gap = send_gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (req_tvalid && !took) begin
         send_gap <= 0;
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
         send_gap <= gap - 1;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain_first && fractions_due.size() != 0)) begin
         nxt = pending_ops.pop_front();
         in_flight <= nxt;
         req_tdata <= {{(REQ_W - TW - 4 * OPW){1'b0}},
                       nxt.b_den, nxt.b_num, nxt.a_den, nxt.a_num, nxt.op};
         req_tvalid <= 1'b1;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      frac_result_type want;
      frac_result_type got;
      int w;
      logic took;
      took = rsp_tvalid && rsp_tready;
      w = recv_wait;
      if (took) begin
         got.num = rsp_tdata[NW-1:0];
         got.den = rsp_tdata[NW+DW-1:NW];
         got.zero_den = rsp_tdata[NW+DW];
         results_seen++;
         if (fractions_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: num %0d den %0d zero_den %0b",
                        got.num, got.den, got.zero_den);
         end else begin
            want = fractions_due.pop_front();
            if (got.num !== want.num || got.den !== want.den ||
                got.zero_den !== want.zero_den) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch on result %0d: expected %0d/%0d zd %0b, ",
                            "got %0d/%0d zd %0b"},
                           results_seen, want.num, want.den, want.zero_den,
                           got.num, got.den, got.zero_den);
            end
         end
         w = (((results_seen / 64) % 3) == 1) ? 0 : int'($urandom_range(0, 15));
      end
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait <= 0;
      end else if (!long_hold_done && items_sent >= 300) begin
         long_hold_done <= 1'b1;
         recv_wait <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (w > 0) begin
         recv_wait <= w - 1;
         rsp_tready <= 1'b0;
      end else begin
         recv_wait <= 0;
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int mode;
      int kind;
      logic [TW-1:0] op;
      int an, ad, bn, bd;

      queue_op(fau_pkg::OP_ADD, 1, 2, 1, 3, 1'b0);
      queue_op(fau_pkg::OP_SUB, 1, 2, 1, 2, 1'b0);
      queue_op(fau_pkg::OP_MUL, 2, 3, -3, 4, 1'b0);
      queue_op(fau_pkg::OP_DIV, 2, 3, 4, -9, 1'b0);
      queue_op(fau_pkg::OP_MUL, -32768, 1, -32768, 1, 1'b0);
      queue_op(fau_pkg::OP_ADD, -32768, 1, -32768, 1, 1'b0);
      queue_op(fau_pkg::OP_SUB, 32767, -32768, -32768, 32767, 1'b0);
      queue_op(fau_pkg::OP_ADD, 32767, 32767, 32767, -32768, 1'b0);
      queue_op(fau_pkg::OP_DIV, -32768, 32767, 32767, -32768, 1'b0);
      queue_op(fau_pkg::OP_MUL, 32767, -32768, 32767, -32768, 1'b0);
      queue_op(fau_pkg::OP_DIV, 5, 7, 0, 3, 1'b0);
      queue_op(fau_pkg::OP_DIV, -5, 7, 0, 3, 1'b0);
      queue_op(fau_pkg::OP_DIV, 0, 7, 0, 3, 1'b0);
      queue_op(fau_pkg::OP_ADD, 3, 0, 4, 5, 1'b0);
      queue_op(fau_pkg::OP_MUL, 0, 0, 4, 5, 1'b0);
      queue_op(fau_pkg::OP_SUB, 0, 0, 0, 0, 1'b0);
      queue_op(fau_pkg::OP_MUL, 0, 5, 7, -3, 1'b0);
      queue_op(fau_pkg::OP_SUB, 3, -4, 3, -4, 1'b0);
      queue_op(fau_pkg::OP_ADD, 0, -32768, 0, 32767, 1'b0);
      queue_op(fau_pkg::OP_DIV, -1, -1, -1, -1, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         kind = int'($urandom_range(0, 9));
         mode = (kind < 6) ? 0 : (kind < 9) ? 1 : 2;
         op = TW'($urandom_range(0, 3));
         an = draw_operand(mode);
         ad = draw_operand(mode);
         bn = draw_operand(mode);
         bd = draw_operand(mode);
         if (kind < 9) begin
            if (ad == 0) ad = 1;
            if (bd == 0) bd = -1;
         end else begin
            case ($urandom_range(0, 3))
               0: ad = 0;
               1: bd = 0;
               2: bn = 0;
               default: begin
                  an = 0;
                  bn = 0;
               end
            endcase
         end
         queue_op(op, an, ad, bn, bd, (i % 100) == 0);
      end

      while (pending_ops.size() != 0 || req_tvalid || fractions_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && fractions_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
